FILE: hw/rtl/icps_pkg.sv
// ----------------------------------------------------------------------------
// icps_pkg
// Shared types and constants for the two-wire command packet slave.
// ----------------------------------------------------------------------------
`default_nettype none

package icps_pkg;

  // Bus event codes
  localparam logic [2:0] EV_WRITE_START = 3'd0;
  localparam logic [2:0] EV_RECEIVE     = 3'd1;
  localparam logic [2:0] EV_STOP        = 3'd2;
  localparam logic [2:0] EV_READ_START  = 3'd3;
  localparam logic [2:0] EV_READ_NEXT   = 3'd4;

  // Command codes in packet byte 1
  localparam logic [7:0] CMD_MOVE     = 8'd1;
  localparam logic [7:0] CMD_TILT     = 8'd2;
  localparam logic [7:0] CMD_ROTATE   = 8'd3;
  localparam logic [7:0] CMD_CLAW     = 8'd4;
  localparam logic [7:0] CMD_SNAPSHOT = 8'd5;

  // Argument codes in packet byte 2
  localparam logic [7:0] ARG_PLUS_ONE  = 8'h01;
  localparam logic [7:0] ARG_MINUS_ONE = 8'hFF;
  localparam logic [7:0] ARG_PLUS_TWO  = 8'h02;
  localparam logic [7:0] ARG_MINUS_TWO = 8'hFE;
  localparam logic [7:0] ARG_ZERO      = 8'h00;

  localparam logic [7:0] PKT_HEADER  = 8'h05;
  localparam logic [7:0] PKT_TRAILER = 8'hFF;
  localparam logic [7:0] REPLY_EMPTY = 8'hFF;

  localparam logic [7:0] TILT_STEP     = 8'd5;
  localparam logic [7:0] ROTATION_STEP = 8'd10;

  localparam logic [7:0] RESET_POS_X    = 8'd10;
  localparam logic [7:0] RESET_POS_Y    = 8'd10;
  localparam logic [7:0] RESET_TILT     = 8'd45;
  localparam logic [7:0] RESET_ROTATION = 8'd0;

  localparam int unsigned STORE_DEPTH = 8;
  localparam logic [3:0] STORE_FULL = 4'd8;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       frame_applied;
  } out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2c_command_packet_slave.sv
// ----------------------------------------------------------------------------
// i2c_command_packet_slave
// Command packet slave behind a two-wire bus event interface.
// ----------------------------------------------------------------------------
// Each input word carries one bus event (write start, byte received, stop,
// read start, next byte requested, other) and a data byte. Every event gives
// exactly one output word: the reply byte for read events, and a flag that
// tells whether a stop found a well-formed packet and applied its command.
// Input channel: in_valid / in_stall / in_data. Output channel: out_valid /
// out_stall / out_data. A word moves when valid is high and stall is low.
// The result passes the input register, then the state update and result
// logic into the output register. Throughput is one word per cycle while the
// receiver does not hold out_stall; the store and actuator update is made as
// results are registered, so back-to-back events never wait on each other.
// When the receiver holds out_stall, the output word stays put, the input
// register holds, and in_stall rises once the input register is full.
// Reset clears both stores and counters, loads the actuator defaults
// (x 10, y 10, tilt 45, rotation 0, claw open) and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_command_packet_slave (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire icps_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output icps_pkg::out_t     out_data
);

  logic           item_valid;
  icps_pkg::in_t  item;
  icps_pkg::out_t res;
  logic           advance;
  logic           fire;

  assign advance  = !out_valid || !out_stall;
  assign fire     = item_valid && advance;
  assign in_stall = item_valid && !advance;

  icps_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= item_valid;
      end
    end
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
    if (fire) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/icps_engine.sv
// ----------------------------------------------------------------------------
// icps_engine
// Packet store, reply store and actuator state; applies one bus event per
// enabled cycle and presents that event's result combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module icps_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire icps_pkg::in_t item,
  output icps_pkg::out_t     res
);

  logic [7:0] receive_store [icps_pkg::STORE_DEPTH];
  logic [7:0] reply_store   [icps_pkg::STORE_DEPTH];
  logic [3:0] receive_count;
  logic [3:0] reply_count;
  logic [7:0] position_x;
  logic [7:0] position_y;
  logic [7:0] tilt_angle;
  logic [7:0] rotation_angle;
  logic       claw_closed;

  logic [3:0] reply_base;
  logic       reply_avail;
  logic       is_read;
  logic       frame_ok;
  logic [7:0] cmd;
  logic [7:0] arg;

  assign cmd      = receive_store[1];
  assign arg      = receive_store[2];
  assign frame_ok = (receive_store[0] == icps_pkg::PKT_HEADER) &&
                    (receive_store[7] == icps_pkg::PKT_TRAILER);

  assign is_read     = (item.mode == icps_pkg::EV_READ_START) ||
                       (item.mode == icps_pkg::EV_READ_NEXT);
  // a read start rewinds the reply pointer before fetching
  assign reply_base  = (item.mode == icps_pkg::EV_READ_START) ? 4'd0 : reply_count;
  assign reply_avail = (reply_base < icps_pkg::STORE_FULL);

  always_comb begin
    res.read_data     = 8'd0;
    res.read_valid    = 1'b0;
    res.frame_applied = 1'b0;
    if (is_read) begin
      res.read_valid = 1'b1;
      res.read_data  = reply_avail ? reply_store[reply_base[2:0]] : icps_pkg::REPLY_EMPTY;
    end
    if (item.mode == icps_pkg::EV_STOP) begin
      res.frame_applied = frame_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < icps_pkg::STORE_DEPTH; i++) begin
        receive_store[i] <= 8'd0;
        reply_store[i]   <= 8'd0;
      end
      receive_count  <= 4'd0;
      reply_count    <= 4'd0;
      position_x     <= icps_pkg::RESET_POS_X;
      position_y     <= icps_pkg::RESET_POS_Y;
      tilt_angle     <= icps_pkg::RESET_TILT;
      rotation_angle <= icps_pkg::RESET_ROTATION;
      claw_closed    <= 1'b0;
    end else if (fire) begin
      case (item.mode)
        icps_pkg::EV_WRITE_START: begin
          receive_count <= 4'd0;
        end
        icps_pkg::EV_RECEIVE: begin
          // drop bytes past the end of the store
          if (receive_count < icps_pkg::STORE_FULL) begin
            receive_store[receive_count[2:0]] <= item.data_byte;
            receive_count <= receive_count + 4'd1;
          end
        end
        icps_pkg::EV_STOP: begin
          if (frame_ok) begin
            case (cmd)
              icps_pkg::CMD_MOVE: begin
                if (arg == icps_pkg::ARG_PLUS_ONE)       position_y <= position_y + 8'd1;
                else if (arg == icps_pkg::ARG_MINUS_ONE) position_y <= position_y - 8'd1;
                else if (arg == icps_pkg::ARG_PLUS_TWO)  position_x <= position_x + 8'd1;
                else if (arg == icps_pkg::ARG_MINUS_TWO) position_x <= position_x - 8'd1;
              end
              icps_pkg::CMD_TILT: begin
                if (arg == icps_pkg::ARG_PLUS_ONE)
                  tilt_angle <= tilt_angle + icps_pkg::TILT_STEP;
                else if (arg == icps_pkg::ARG_MINUS_ONE)
                  tilt_angle <= tilt_angle - icps_pkg::TILT_STEP;
              end
              icps_pkg::CMD_ROTATE: begin
                if (arg == icps_pkg::ARG_PLUS_ONE)
                  rotation_angle <= rotation_angle + icps_pkg::ROTATION_STEP;
                else if (arg == icps_pkg::ARG_MINUS_ONE)
                  rotation_angle <= rotation_angle - icps_pkg::ROTATION_STEP;
              end
              icps_pkg::CMD_CLAW: begin
                if (arg == icps_pkg::ARG_PLUS_ONE)  claw_closed <= 1'b1;
                else if (arg == icps_pkg::ARG_ZERO) claw_closed <= 1'b0;
              end
              icps_pkg::CMD_SNAPSHOT: begin
                reply_store[0] <= icps_pkg::PKT_HEADER;
                reply_store[1] <= position_x;
                reply_store[2] <= position_y;
                reply_store[3] <= tilt_angle;
                reply_store[4] <= rotation_angle;
                reply_store[5] <= {7'd0, claw_closed};
                reply_store[6] <= 8'd0;
                reply_store[7] <= icps_pkg::PKT_TRAILER;
              end
              default: begin
              end
            endcase
          end
        end
        icps_pkg::EV_READ_START, icps_pkg::EV_READ_NEXT: begin
          if (reply_avail) begin
            reply_count <= reply_base + 4'd1;
          end else begin
            reply_count <= reply_base;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
